FILE: rtl/prwg_pkg.sv
package prwg_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIME     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 2'd3;

  localparam int COUNT_W     = 4;
  localparam int INDEX_W     = 3;
  localparam int COUNT_RESET = 2;
  localparam int PERIOD_RESET = 1000;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T0,
    S_TN,
    S_CHK,
    S_SEG1,
    S_OFF,
    S_SETUP,
    S_DBL,
    S_ADD,
    S_FIN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_SEG,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    cap_tick;
    logic    mem_wr;
    rd_sel_t rd_sel;
    logic    cap_first;
    logic    cap_span;
    logic    cap_e0;
    logic    wrap;
    logic    cap_seg1;
    logic    cap_off;
    logic    setup;
    logic    div_dbl;
    logic    div_add;
    logic    res_clr;
    logic    res_calc;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic past_stop;
    logic at_end;
    logic in_seg;
    logic dur_zero;
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: rtl/periodic_ramp_waveform_generator_core.sv
// Channel   Direction  Beat contents
// in_       input      action, point_index, point_time, point_level
// out_      output     level, active
// cfg_      input      index, wdata (write only)
//
// A load beat writes the RAM; a tick beat steps S_T0, S_TN, S_CHK and, in a ramp
// segment, S_SEG1, S_OFF, S_SETUP, S_DBL/S_ADD pairs (none on a zero-length one)
// and S_FIN; the divide gives one level bit per pair. Breakpoints sit in one RAM,
// read via a register. Reset is synchronous, active low; the RAM is not cleared.
// in_stall is high while a beat is in work; the out_ register holds one finished
// beat while the next input beat is taken, and a stalled full one adds its wait.
module periodic_ramp_waveform_generator_core #(
  parameter int MAX_POINTS = 8,
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [prwg_pkg::INDEX_W-1:0]   in_point_index,
  input  logic [TIME_BITS-1:0]           in_point_time,
  input  logic signed [LEVEL_BITS-1:0]   in_point_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [LEVEL_BITS-1:0]   out_level,
  output logic                           out_active,
  input  logic                           cfg_we,
  input  logic [prwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]           cfg_wdata
);
  import prwg_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  prwg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  prwg_dp #(
    .MAX_POINTS (MAX_POINTS),
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_point_index (in_point_index),
    .in_point_time  (in_point_time),
    .in_point_level (in_point_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .out_active     (out_active)
  );

endmodule

FILE: rtl/prwg_ctrl.sv
module prwg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_stall,
  input  prwg_pkg::ctrl_sts_t  sts,
  output prwg_pkg::ctrl_cmd_t  cmd
);
  import prwg_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_LOAD) ? S_DONE : S_T0;
        end
      end
      S_T0:  state_nxt = S_TN;
      S_TN:  state_nxt = S_CHK;
      S_CHK: begin
        if (sts.past_stop || sts.at_end || !sts.in_seg) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SEG1;
        end
      end
      S_SEG1:  state_nxt = S_OFF;
      S_OFF:   state_nxt = S_SETUP;
      S_SETUP: state_nxt = sts.dur_zero ? S_FIN : S_DBL;
      S_DBL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = sts.div_last ? S_FIN : S_DBL;
      S_FIN:   state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_FIRST;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.mem_wr  = 1'b1;
            cmd.res_clr = 1'b1;
          end else begin
            cmd.cap_tick = 1'b1;
          end
        end
      end
      S_T0: begin
        cmd.cap_first = 1'b1;
        cmd.rd_sel    = RD_LAST;
      end
      S_TN: begin
        cmd.cap_span = 1'b1;
        cmd.rd_sel   = RD_SEG;
      end
      S_CHK: begin
        cmd.cap_e0 = 1'b1;
        cmd.rd_sel = RD_NEXT;
        if (sts.past_stop) begin
          cmd.res_clr = 1'b1;
        end else if (sts.at_end) begin
          cmd.wrap    = 1'b1;
          cmd.res_clr = 1'b1;
        end else if (!sts.in_seg) begin
          cmd.res_clr = 1'b1;
        end
      end
      S_SEG1:  cmd.cap_seg1 = 1'b1;
      S_OFF:   cmd.cap_off  = 1'b1;
      S_SETUP: cmd.setup    = 1'b1;
      S_DBL:   cmd.div_dbl  = 1'b1;
      S_ADD:   cmd.div_add  = 1'b1;
      S_FIN:   cmd.res_calc = 1'b1;
      S_DONE:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/prwg_dp.sv
module prwg_dp #(
  parameter int MAX_POINTS = 8,
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  prwg_pkg::ctrl_cmd_t            cmd,
  output prwg_pkg::ctrl_sts_t            sts,
  input  logic [prwg_pkg::INDEX_W-1:0]   in_point_index,
  input  logic [TIME_BITS-1:0]           in_point_time,
  input  logic signed [LEVEL_BITS-1:0]   in_point_level,
  input  logic                           cfg_we,
  input  logic [prwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]           cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [LEVEL_BITS-1:0]   out_level,
  output logic                           out_active
);
  import prwg_pkg::*;

  localparam int TW = TIME_BITS;
  localparam int LW = LEVEL_BITS;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(LEVEL_BITS);

  logic [TW+LW-1:0] mem [MAX_POINTS];
  logic [TW+LW-1:0] rd_q;
  logic [PW-1:0]    rd_addr;
  logic [PW-1:0]    wr_addr;
  logic             wr_ok;

  logic [TW-1:0]      period_r;
  logic [TW-1:0]      stop_r;
  logic [COUNT_W-1:0] pc_r;

  logic [TW-1:0] tick_r;
  logic [TW-1:0] t_r;
  logic [TW-1:0] ps_r;
  logic [PW-1:0] seg_r;

  logic [TW-1:0]        tfirst_r;
  logic [TW-1:0]        span_r;
  logic [TW-1:0]        t0_r;
  logic signed [LW-1:0] l0_r;
  logic [TW-1:0]        dur_r;
  logic [TW-1:0]        segstart_r;
  logic [TW-1:0]        segend_r;
  logic [LW-1:0]        diff_r;
  logic                 neg_r;
  logic [TW-1:0]        off_r;

  logic [TW-1:0] rem_r;
  logic [LW-1:0] q_r;
  logic [LW-1:0] a_r;
  logic [CW-1:0] cnt_r;

  logic signed [LW-1:0] res_level_r;
  logic                 res_active_r;
  logic                 out_valid_r;
  logic signed [LW-1:0] out_level_r;
  logic                 out_active_r;

  logic [31:0]          pc32;
  logic [PW-1:0]        last;
  logic [TW-1:0]        rd_time;
  logic signed [LW-1:0] rd_level;
  logic [TW-1:0]        pend;
  logic signed [LW:0]   dl;
  logic [LW:0]          dl_mag;
  logic [TW:0]          dbl_sum;
  logic [TW:0]          add_sum;
  logic [TW:0]          dur_x;
  logic [TW-1:0]        t_inc;
  logic signed [LW:0]   fin_sum;

  assign rd_time  = rd_q[TW+LW-1:LW];
  assign rd_level = rd_q[LW-1:0];
  assign pc32     = 32'(pc_r);

  always_comb begin
    if (pc32 < 32'd2) begin
      last = PW'(1);
    end else if (pc32 > 32'(MAX_POINTS)) begin
      last = PW'(MAX_POINTS - 1);
    end else begin
      last = PW'(pc32 - 32'd1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = last;
      RD_SEG:   rd_addr = seg_r;
      RD_NEXT:  rd_addr = seg_r + PW'(1);
      default:  rd_addr = '0;
    endcase
  end

  assign wr_addr = PW'(in_point_index);
  assign wr_ok   = (32'(in_point_index) < 32'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      mem[wr_addr] <= {in_point_time, in_point_level};
    end
    rd_q <= mem[rd_addr];
  end

  assign pend    = ps_r + span_r;
  assign dur_x   = {1'b0, dur_r};
  assign dbl_sum = {rem_r, 1'b0};
  assign add_sum = {1'b0, rem_r} + {1'b0, off_r};
  assign t_inc   = t_r + TW'(1);
  assign dl      = {rd_level[LW-1], rd_level} - {l0_r[LW-1], l0_r};
  assign dl_mag  = dl[LW] ? (LW+1)'(-dl) : dl;
  assign fin_sum = neg_r ? ({l0_r[LW-1], l0_r} - {1'b0, q_r})
                         : ({l0_r[LW-1], l0_r} + {1'b0, q_r});

  always_comb begin
    sts.past_stop = (t_r > stop_r);
    sts.at_end    = (t_r >= pend);
    sts.in_seg    = (t_r >= ps_r) && (seg_r < last);
    sts.dur_zero  = (dur_r == '0);
    sts.div_last  = (cnt_r == '0);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // config registers and pattern position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r      <= TW'(PERIOD_RESET);
      stop_r        <= '0;
      pc_r          <= COUNT_W'(COUNT_RESET);
      tick_r        <= '0;
      ps_r          <= '0;
      seg_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_DELAY: begin
            ps_r          <= cfg_wdata;
            seg_r         <= '0;
          end
          CFG_REPEAT_PERIOD: period_r <= cfg_wdata;
          CFG_STOP_TIME:     stop_r   <= cfg_wdata;
          CFG_POINT_COUNT:   pc_r     <= cfg_wdata[COUNT_W-1:0];
          default:           pc_r     <= pc_r;
        endcase
      end
      if (cmd.cap_tick) begin
        tick_r <= tick_r + TW'(1);
      end
      if (cmd.wrap) begin
        ps_r  <= ps_r + period_r;
        seg_r <= '0;
      end
      if (cmd.setup && (t_inc >= segend_r)) begin
        seg_r <= seg_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_tick) begin
      t_r <= tick_r;
    end
    if (cmd.cap_first) begin
      tfirst_r <= rd_time;
    end
    if (cmd.cap_span) begin
      span_r <= rd_time - tfirst_r;
    end
    if (cmd.cap_e0) begin
      t0_r <= rd_time;
      l0_r <= rd_level;
    end
    if (cmd.cap_seg1) begin
      dur_r      <= rd_time - t0_r;
      segstart_r <= ps_r + t0_r;
      segend_r   <= ps_r + rd_time;
      neg_r      <= dl[LW];
      diff_r     <= dl_mag[LW-1:0];
    end
    if (cmd.cap_off) begin
      off_r <= (t_r >= segstart_r) ? (t_r - segstart_r) : '0;
    end
    if (cmd.setup) begin
      if (off_r > dur_r) begin
        off_r <= dur_r;
      end
      rem_r <= '0;
      q_r   <= '0;
      a_r   <= diff_r;
      cnt_r <= CW'(LW - 1);
    end
    // q = floor(diff * off / dur), one diff bit per double/add pair
    if (cmd.div_dbl) begin
      if (dbl_sum >= dur_x) begin
        rem_r <= TW'(dbl_sum - dur_x);
        q_r   <= {q_r[LW-2:0], 1'b1};
      end else begin
        rem_r <= dbl_sum[TW-1:0];
        q_r   <= {q_r[LW-2:0], 1'b0};
      end
    end
    if (cmd.div_add) begin
      if (a_r[LW-1]) begin
        if (add_sum >= dur_x) begin
          rem_r <= TW'(add_sum - dur_x);
          q_r   <= q_r + LW'(1);
        end else begin
          rem_r <= add_sum[TW-1:0];
        end
      end
      a_r   <= {a_r[LW-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.res_clr) begin
      res_level_r  <= '0;
      res_active_r <= 1'b0;
    end
    if (cmd.res_calc) begin
      res_level_r  <= fin_sum[LW-1:0];
      res_active_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_level_r  <= res_level_r;
      out_active_r <= res_active_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_active = out_active_r;

endmodule
